>>> rtl/nms_pkg.sv
// Package for the neighbor-mean smoothing filter: sizes, command codes and the
// structs that pass between the register block, front end, queue and back end.
// No dependencies.
package nms_pkg;

  localparam int MAX_LINE  = 1024;
  localparam int COL_W     = $clog2(MAX_LINE);
  localparam int SAMPLE_W  = 16;
  localparam int LEN_W     = 11;
  localparam int ROW_W     = 13;
  localparam int MAX_LINES = 4096;
  localparam int MIN_DIM   = 3;
  localparam int ROWSUM_W  = SAMPLE_W + 2;
  localparam int SUM_W     = SAMPLE_W + 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef enum logic [0:0] {
    REG_LINE_LENGTH = 1'b0,
    REG_LINE_COUNT  = 1'b1
  } nms_reg_t;

  typedef struct packed {
    logic [LEN_W-1:0] line_length;
    logic [ROW_W-1:0] line_count;
    logic             restart;
  } nms_cfg_t;

  // One classified word: store column, sample value and the neighbor masks.
  typedef struct packed {
    logic [COL_W-1:0]           col;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       res;
    logic                       use_c0;
    logic                       use_c2;
    logic                       top_ok;
    logic                       bot_ok;
    logic                       last;
  } nms_item_t;

endpackage

>>> rtl/nms_regs.sv
// APB-style configuration registers of the smoothing filter.
// Depends on nms_pkg.
module nms_regs import nms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output nms_cfg_t              cfg
);

  logic [LEN_W-1:0] line_length;
  logic [ROW_W-1:0] line_count;
  logic             wr_en;
  nms_reg_t         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = nms_reg_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= LEN_W'(128);
      line_count  <= ROW_W'(128);
    end else if (wr_en) begin
      case (reg_sel)
        REG_LINE_LENGTH: line_length <= pwdata[LEN_W-1:0];
        REG_LINE_COUNT:  line_count  <= pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LINE_LENGTH: prdata = APB_DATA_W'(line_length);
      REG_LINE_COUNT:  prdata = APB_DATA_W'(line_count);
      default:         prdata = '0;
    endcase
  end

  assign cfg.line_length = line_length;
  assign cfg.line_count  = line_count;
  // Any write restarts the frame.
  assign cfg.restart     = wr_en;

endmodule

>>> rtl/nms_front.sv
// Front end: accepts words, tracks the raster position and classifies each
// word into the store column, sample value and neighbor masks. Depends on nms_pkg.
module nms_front import nms_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  nms_cfg_t                   cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       command,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       queue_full,
  output logic                       push,
  output nms_item_t                  item
);

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic [LEN_W-1:0] len_eff;
  logic [ROW_W-1:0] cnt_eff;
  logic             wrap;
  logic             first;

  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    if (cfg.line_length < LEN_W'(MIN_DIM)) begin
      len_eff = LEN_W'(MIN_DIM);
    end else if (32'(cfg.line_length) > MAX_LINE) begin
      len_eff = LEN_W'(MAX_LINE);
    end else begin
      len_eff = cfg.line_length;
    end
    if (cfg.line_count < ROW_W'(MIN_DIM)) begin
      cnt_eff = ROW_W'(MIN_DIM);
    end else if (32'(cfg.line_count) > MAX_LINES) begin
      cnt_eff = ROW_W'(MAX_LINES);
    end else begin
      cnt_eff = cfg.line_count;
    end
  end

  // A word at column zero closes the last cell of the line two rows up; any
  // other word closes the cell one row up and one column to the left.
  always_comb begin
    wrap = (col == '0) && (row >= ROW_W'(2));
    first = (col != '0) && (row != '0);
    item.col    = col;
    item.sample = (command == CMD_FLUSH) ? '0 : sample;
    item.res    = wrap || first;
    item.use_c0 = wrap || (col >= COL_W'(2));
    item.use_c2 = !wrap;
    item.top_ok = wrap ? (row >= ROW_W'(3)) : (row >= ROW_W'(2));
    item.bot_ok = wrap ? (row <= cnt_eff) : (row < cnt_eff);
    item.last   = wrap && (row == cnt_eff + ROW_W'(1));
  end

  always_comb begin
    col_next = col;
    row_next = row;
    if (cfg.restart) begin
      col_next = '0;
      row_next = '0;
    end else if (push) begin
      if (item.last) begin
        col_next = '0;
        row_next = '0;
      end else if (32'(col) + 32'd1 >= 32'(len_eff)) begin
        col_next = '0;
        row_next = row + ROW_W'(1);
      end else begin
        col_next = col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

>>> rtl/nms_queue.sv
// Short queue of classified words between the front and back ends.
// Depends on nms_pkg.
module nms_queue import nms_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  nms_item_t push_item,
  input  logic      pop,
  output nms_item_t head,
  output logic      full,
  output logic      empty
);

  nms_item_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/nms_back.sv
// Back end: line stores, 3x3 window, masked row sums and the output register.
// Stages: store read, window shift, row sums, final sum and shift. Depends on nms_pkg.
module nms_back import nms_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  nms_item_t                   head,
  input  logic                        empty,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  smoothed,
  output logic                        frame_end
);

  // Each store word holds {line above, middle line} for one column. Entries
  // read before the current frame wrote them only feed masked neighbors.
  logic [2*SAMPLE_W-1:0] store [MAX_LINE];
  logic [2*SAMPLE_W-1:0] rd_data;

  logic                  en;
  logic                  s1_valid;
  nms_item_t             s1;
  logic                  s2_valid;
  nms_item_t             s2;
  logic                  s3_valid;
  logic                  s3_res;
  logic                  s3_last;
  logic signed [ROWSUM_W-1:0] row0;
  logic signed [ROWSUM_W-1:0] row1;
  logic signed [ROWSUM_W-1:0] row2;
  logic signed [ROWSUM_W-1:0] row0_sum;
  logic signed [ROWSUM_W-1:0] row1_sum;
  logic signed [ROWSUM_W-1:0] row2_sum;
  logic signed [SUM_W-1:0]    total;
  logic signed [SAMPLE_W-1:0] win [3][3];

  function automatic logic signed [ROWSUM_W-1:0] term(input logic signed [SAMPLE_W-1:0] x,
                                                      input logic use_it);
    term = use_it ? ROWSUM_W'(x) : '0;
  endfunction

  // The whole back end moves together unless a result waits at the output.
  assign en  = !out_valid || out_ready;
  assign pop = en && !empty;

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      store[s1.col] <= {rd_data[SAMPLE_W-1:0], s1.sample};
    end
    if (pop) begin
      rd_data <= store[head.col];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1 <= head;
    end
    if (en && s1_valid) begin
      s2 <= s1;
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= rd_data[2*SAMPLE_W-1:SAMPLE_W];
      win[1][2] <= rd_data[SAMPLE_W-1:0];
      win[2][2] <= s1.sample;
    end
    if (en && s2_valid) begin
      s3_res   <= s2.res;
      s3_last  <= s2.last;
      row0_sum <= row0;
      row1_sum <= row1;
      row2_sum <= row2;
    end
    if (en) begin
      smoothed  <= total[SUM_W-1:3];
      frame_end <= s3_last;
    end
  end

  // Masked row sums of the window after the current word has shifted in.
  always_comb begin
    row0 = s2.top_ok ? term(win[0][0], s2.use_c0) + term(win[0][1], 1'b1)
                       + term(win[0][2], s2.use_c2) : '0;
    row1 = term(win[1][0], s2.use_c0) + term(win[1][2], s2.use_c2);
    row2 = s2.bot_ok ? term(win[2][0], s2.use_c0) + term(win[2][1], 1'b1)
                       + term(win[2][2], s2.use_c2) : '0;
    total = SUM_W'(row0_sum) + SUM_W'(row1_sum) + SUM_W'(row2_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= !empty;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid && s3_res;
    end
  end

endmodule

>>> rtl/neighbour_mean_smoothing_filter_core.sv
// Neighbor-mean smoothing filter, top level: register block, front end, queue, back end.
// Throughput: one word per cycle while the output is taken; the back end advances
// when the output register is empty or being taken; the queue buffers four words.
// Path of a word: queue, store read, window shift, row sums, output register.
// Reset clears counters, queue and valid bits; line stores need no clearing pass.
module neighbour_mean_smoothing_filter_core import nms_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [APB_ADDR_W-1:0]       paddr,
  input  logic [APB_DATA_W-1:0]       pwdata,
  output logic [APB_DATA_W-1:0]       prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        command,
  input  logic signed [SAMPLE_W-1:0]  sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  smoothed,
  output logic                        frame_end
);

  nms_cfg_t  cfg;
  nms_item_t front_item;
  nms_item_t head;
  logic      push;
  logic      pop;
  logic      queue_full;
  logic      queue_empty;

  nms_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nms_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .sample     (sample),
    .queue_full (queue_full),
    .push       (push),
    .item       (front_item)
  );

  nms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .head      (head),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  nms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (queue_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .smoothed  (smoothed),
    .frame_end (frame_end)
  );

endmodule
